/* sv/cbrf_pkg.sv */
// ----------------------------------------------------------------------------
// cbrf_pkg
// Shared constants, types and codes of the chunked byte ring FIFO.
// ----------------------------------------------------------------------------
package cbrf_pkg;

  localparam int DEPTH_LOG2      = 12;
  localparam int MAX_CHUNK_BYTES = 8;
  localparam int LANE_W          = 3;
  localparam int LANES           = 1 << LANE_W;
  localparam int ROW_W           = DEPTH_LOG2 - LANE_W;
  localparam int SIZE_W          = 4;
  localparam int NB_W            = 4;
  localparam int FILL_W          = 12;
  localparam int SIZE_RESET      = (12 > DEPTH_LOG2) ? DEPTH_LOG2 : 12;

  typedef logic [DEPTH_LOG2-1:0] pos_t;
  typedef logic [LANE_W-1:0]     lane_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [SIZE_W-1:0]     size_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic  [LANES-1:0] hit;
    row_t  [LANES-1:0] row;
    lane_t [LANES-1:0] src;
    lane_t [LANES-1:0] lane_bank;
  } bank_map_t;

endpackage

/* sv/cbrf_req_if.sv */
// ----------------------------------------------------------------------------
// cbrf_req_if
// Request channel: one chunk access per item.
// ----------------------------------------------------------------------------
interface cbrf_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [3:0]  nbytes;
  logic [63:0] wdata;

  modport source (output valid, output cmd, output nbytes, output wdata, input ready);
  modport sink   (input valid, input cmd, input nbytes, input wdata, output ready);
endinterface

/* sv/cbrf_rsp_if.sv */
// ----------------------------------------------------------------------------
// cbrf_rsp_if
// Response channel: one result item per accepted request.
// ----------------------------------------------------------------------------
interface cbrf_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [63:0] rdata;
  logic [11:0] fill_level;

  modport source (output valid, output ok, output rdata, output fill_level, input ready);
  modport sink   (input valid, input ok, input rdata, input fill_level, output ready);
endinterface

/* sv/chunked_byte_ring_fifo.sv */
// ----------------------------------------------------------------------------
// chunked_byte_ring_fifo
// Byte ring FIFO accessed in chunks of up to eight bytes, with one slot free.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    cmd, nbytes, wdata
//   rsp      out  valid/ready    ok, rdata, fill_level
//   cfg      in   cfg_we         cfg_wdata (size_log2)
//
// For each item the bank RAMs are accessed at the accepting edge, and the
// registered read data is assembled into the result in the cycle after.
// A new item is taken only once the result register is free or being emptied.
// Reset is synchronous; the bytes stored are not cleared and need no pass.
// A stalled result holds req off, so writes always land before the next read.
// ----------------------------------------------------------------------------
module chunked_byte_ring_fifo
  import cbrf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  cbrf_req_if.sink          req,
  cbrf_rsp_if.source        rsp
);

  size_t     size_log2;
  pos_t      wp;
  pos_t      rp;
  pos_t      wp_next;
  pos_t      rp_next;
  pos_t      mask;
  pos_t      space;
  pos_t      fill;
  pos_t      base;
  pos_t      nb_pos;
  logic      nb_ok;
  logic      wr_ok;
  logic      rd_ok;
  logic      acc;
  bank_map_t map;

  logic                     pend;
  logic                     pend_ok;
  logic                     pend_rd;
  logic [NB_W-1:0]          pend_n;
  lane_t [LANES-1:0]        pend_bank;
  pos_t                     pend_fill;
  logic [LANES-1:0][7:0]    bank_q;
  logic [63:0]              rdata_next;

  assign mask   = ~({DEPTH_LOG2{1'b1}} << size_log2);
  assign nb_pos = pos_t'(req.nbytes);
  assign nb_ok  = req.nbytes <= NB_W'(MAX_CHUNK_BYTES);
  assign space  = (rp - wp - pos_t'(1)) & mask;
  assign fill   = (wp - rp) & mask;
  assign wr_ok  = nb_ok && (req.cmd == CMD_WRITE) && (space >= nb_pos);
  assign rd_ok  = nb_ok && (req.cmd == CMD_READ) && (fill >= nb_pos);
  assign base   = (req.cmd == CMD_READ) ? rp : wp;
  assign wp_next = wr_ok ? ((wp + nb_pos) & mask) : wp;
  assign rp_next = rd_ok ? ((rp + nb_pos) & mask) : rp;

  assign req.ready = !pend && (!rsp.valid || rsp.ready);
  assign acc       = req.valid && req.ready;

  cbrf_lane_map u_map (
    .base   (base),
    .mask   (mask),
    .nbytes (req.nbytes),
    .map    (map)
  );

  for (genvar j = 0; j < LANES; j++) begin : g_bank
    cbrf_byte_ram #(.ADDR_W(ROW_W), .DATA_W(8)) u_ram (
      .clk  (clk),
      .we   (acc && wr_ok && map.hit[j]),
      .re   (acc && rd_ok),
      .addr (map.row[j]),
      .wd   (req.wdata[{map.src[j], 3'b000} +: 8]),
      .q    (bank_q[j])
    );
  end

  always_comb begin
    rdata_next = '0;
    for (int i = 0; i < LANES; i++) begin
      if (pend_rd && (NB_W'(i) < pend_n)) begin
        rdata_next[8*i +: 8] = bank_q[pend_bank[i]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= size_t'(SIZE_RESET);
      wp        <= '0;
      rp        <= '0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          size_log2 <= size_t'(1);
        end else if (cfg_wdata > size_t'(DEPTH_LOG2)) begin
          size_log2 <= size_t'(DEPTH_LOG2);
        end else begin
          size_log2 <= cfg_wdata;
        end
        wp <= '0;
        rp <= '0;
      end else if (acc) begin
        wp <= wp_next;
        rp <= rp_next;
      end
      pend <= acc;
      if (pend) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_ok   <= wr_ok || rd_ok || (nb_ok && (req.cmd == CMD_WRITE) && (nb_pos == '0));
      pend_rd   <= rd_ok;
      pend_n    <= req.nbytes;
      pend_bank <= map.lane_bank;
      pend_fill <= (wp_next - rp_next) & mask;
    end
    if (pend) begin
      rsp.ok         <= pend_ok;
      rsp.rdata      <= rdata_next;
      rsp.fill_level <= FILL_W'(pend_fill);
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !(req.valid && req.ready))
    else $error("item accepted while the previous one is in flight");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && !wr_ok && !rd_ok && !cfg_we) |=> $stable(wp) && $stable(rp))
    else $error("refused access moved a position");

  a_fill_in_ring: assert property (@(posedge clk) disable iff (rst)
    pend |=> (rsp.valid && (pos_t'(rsp.fill_level) <= mask)))
    else $error("result not presented or fill level beyond ring size");

endmodule

/* sv/cbrf_byte_ram.sv */
// ----------------------------------------------------------------------------
// cbrf_byte_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cbrf_byte_ram #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wd,
  output logic [DATA_W-1:0] q
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    if (re) begin
      q <= mem[addr];
    end
  end

endmodule

/* sv/cbrf_lane_map.sv */
// ----------------------------------------------------------------------------
// cbrf_lane_map
// Maps the bytes of one chunk onto the byte banks and their rows.
// ----------------------------------------------------------------------------
module cbrf_lane_map
  import cbrf_pkg::*;
(
  input  pos_t            base,
  input  pos_t            mask,
  input  logic [NB_W-1:0] nbytes,
  output bank_map_t       map
);

  pos_t addr [LANES];

  always_comb begin
    map = '0;
    for (int i = 0; i < LANES; i++) begin
      addr[i] = (base + pos_t'(i)) & mask;
      map.lane_bank[i] = addr[i][LANE_W-1:0];
    end
    for (int j = 0; j < LANES; j++) begin
      for (int i = 0; i < LANES; i++) begin
        if ((NB_W'(i) < nbytes) && (addr[i][LANE_W-1:0] == lane_t'(j))) begin
          map.hit[j] = 1'b1;
          map.row[j] = addr[i][DEPTH_LOG2-1:LANE_W];
          map.src[j] = lane_t'(i);
        end
      end
    end
  end

endmodule

/* test/cbrf_checker.sv */
// ----------------------------------------------------------------------------
// cbrf_checker
// Watches the request, response and size register of the chunked byte ring
// FIFO. It keeps its own copy of the ring and its positions, works out the
// result of every accepted request, and compares each accepted response with
// the oldest result still owed. It reports the error count and the number of
// results still owed.
// ----------------------------------------------------------------------------
module cbrf_checker
  import cbrf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  cbrf_req_if               req,
  cbrf_rsp_if               rsp,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic              ok;
    logic [63:0]       rdata;
    logic [FILL_W-1:0] fill_level;
  } chunk_result_t;

  size_t         ring_log2;
  pos_t          wr_pos;
  pos_t          rd_pos;
  logic [7:0]    ring_bytes [1 << DEPTH_LOG2];
  chunk_result_t owed_results [$];

  function automatic pos_t ring_mask();
    logic [DEPTH_LOG2:0] span;
    span = (DEPTH_LOG2 + 1)'(1);
    span = span << ring_log2;
    return pos_t'(span - 1'b1);
  endfunction

  function automatic chunk_result_t chunk_access(input cmd_t op,
                                                 input logic [NB_W-1:0] len,
                                                 input logic [63:0] data);
    chunk_result_t res;
    pos_t          mask;
    pos_t          room;
    res = '0;
    mask = ring_mask();
    if (len <= MAX_CHUNK_BYTES) begin
      if (op == CMD_WRITE) begin
        room = (rd_pos - wr_pos - 1'b1) & mask;
        if (room >= len) begin
          for (int i = 0; i < len; i++) begin
            ring_bytes[(wr_pos + pos_t'(i)) & mask] = data[8*i +: 8];
          end
          wr_pos = (wr_pos + pos_t'(len)) & mask;
          res.ok = 1'b1;
        end
      end else if (((wr_pos - rd_pos) & mask) >= len) begin
        for (int i = 0; i < len; i++) begin
          res.rdata[8*i +: 8] = ring_bytes[(rd_pos + pos_t'(i)) & mask];
        end
        rd_pos = (rd_pos + pos_t'(len)) & mask;
        res.ok = 1'b1;
      end
    end
    res.fill_level = FILL_W'((wr_pos - rd_pos) & mask);
    return res;
  endfunction

  always @(posedge clk) begin
    chunk_result_t want;
    if (rst) begin
      ring_log2 = size_t'(SIZE_RESET);
      wr_pos = '0;
      rd_pos = '0;
      owed_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata < 1) begin
          ring_log2 = size_t'(1);
        end else if (cfg_wdata > DEPTH_LOG2) begin
          ring_log2 = size_t'(DEPTH_LOG2);
        end else begin
          ring_log2 = cfg_wdata;
        end
        wr_pos = '0;
        rd_pos = '0;
      end
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected response item: ok=%0b rdata=%h fill=%0d",
                     rsp.ok, rsp.rdata, rsp.fill_level);
          end
        end else begin
          want = owed_results.pop_front();
          if (rsp.ok !== want.ok || rsp.rdata !== want.rdata ||
              rsp.fill_level !== want.fill_level) begin
            errors++;
            if (errors <= 10) begin
              $display("response mismatch: expected ok=%0b rdata=%h fill=%0d",
                       want.ok, want.rdata, want.fill_level);
              $display("                   actual   ok=%0b rdata=%h fill=%0d",
                       rsp.ok, rsp.rdata, rsp.fill_level);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        owed_results.push_back(chunk_access(cmd_t'(req.cmd), req.nbytes, req.wdata));
      end
    end
    pending = owed_results.size();
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the chunked byte ring FIFO. A short directed sequence covers
// empty and full rings, zero-length and oversized chunks, a ring of one usable
// byte and out-of-range size values. Random chunk traffic then runs in phases
// with different ring sizes and idle and stall rates, one of them with a long
// response hold-off that backs the block up. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top
  import cbrf_pkg::*;
();

  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 80;
  localparam int PHASES      = 5;
  localparam int PHASE_SIZE  [PHASES] = '{3, 6, 1, 13, 4};
  localparam int PHASE_IDLE  [PHASES] = '{0, 88, 0, 7, 0};
  localparam int PHASE_STALL [PHASES] = '{0, 0, 88, 7, 0};

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int                idle_pct;
  int                stall_pct;
  bit                hold_req;
  bit                hold_done;
  int                errors;
  int                pending;

  cbrf_req_if req_ch ();
  cbrf_rsp_if rsp_ch ();

  chunked_byte_ring_fifo u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  cbrf_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic offer_chunk(input cmd_t op, input logic [NB_W-1:0] len,
                             input logic [63:0] data);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.cmd    <= op;
    req_ch.nbytes <= len;
    req_ch.wdata  <= data;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ring_size(input logic [SIZE_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_chunks(input int count);
    int            pick;
    int            write_pct;
    logic [NB_W-1:0] len;
    cmd_t          op;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        len = '0;
      end else if (pick < 6) begin
        len = NB_W'($urandom_range(15, MAX_CHUNK_BYTES + 1));
      end else begin
        len = NB_W'($urandom_range(MAX_CHUNK_BYTES, 1));
      end
      write_pct = ((i / 12) % 2 == 0) ? 75 : 30;
      op = ($urandom_range(99) < write_pct) ? CMD_WRITE : CMD_READ;
      offer_chunk(op, len, {$urandom, $urandom});
    end
  endtask

  initial begin
    idle_pct      = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.cmd    <= CMD_WRITE;
    req_ch.nbytes <= '0;
    req_ch.wdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_chunk(CMD_READ, 4'd4, 64'h0);
    offer_chunk(CMD_WRITE, 4'd0, 64'h0123_4567_89ab_cdef);
    offer_chunk(CMD_READ, 4'd0, 64'h0);
    offer_chunk(CMD_WRITE, 4'd9, 64'hffff_ffff_ffff_ffff);
    offer_chunk(CMD_READ, 4'd15, 64'h0);
    offer_chunk(CMD_WRITE, 4'd8, 64'hffff_ffff_ffff_ffff);
    offer_chunk(CMD_WRITE, 4'd8, 64'h0);
    offer_chunk(CMD_WRITE, 4'd1, 64'hffff_ffff_ffff_ffa5);
    offer_chunk(CMD_WRITE, 4'd3, {$urandom, $urandom});
    offer_chunk(CMD_READ, 4'd8, 64'h0);
    offer_chunk(CMD_READ, 4'd8, 64'h0);
    offer_chunk(CMD_READ, 4'd4, 64'h0);
    offer_chunk(CMD_READ, 4'd1, 64'h0);

    set_ring_size(4'd0);
    offer_chunk(CMD_WRITE, 4'd1, 64'h0000_0000_0000_005a);
    offer_chunk(CMD_WRITE, 4'd1, 64'h0000_0000_0000_00c3);
    offer_chunk(CMD_WRITE, 4'd2, 64'h0000_0000_0000_ffff);
    offer_chunk(CMD_READ, 4'd2, 64'h0);
    offer_chunk(CMD_READ, 4'd1, 64'h0);
    offer_chunk(CMD_WRITE, 4'd8, 64'h8000_0000_0000_0001);

    set_ring_size(4'd15);
    offer_chunk(CMD_WRITE, 4'd7, {$urandom, $urandom});
    offer_chunk(CMD_READ, 4'd7, 64'h0);

    for (int p = 0; p < PHASES; p++) begin
      set_ring_size(SIZE_W'(PHASE_SIZE[p]));
      idle_pct  = PHASE_IDLE[p];
      stall_pct = PHASE_STALL[p];
      if (p == PHASES - 1) begin
        hold_req = 1'b1;
      end
      random_chunks(PHASE_ITEMS);
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
sv/cbrf_pkg.sv
sv/cbrf_req_if.sv
sv/cbrf_rsp_if.sv
sv/cbrf_byte_ram.sv
sv/cbrf_lane_map.sv
sv/chunked_byte_ring_fifo.sv
test/cbrf_checker.sv
test/tb_top.sv
